>>> design/mpp_pkg.sv
// Shared types and constants for the MQTT PUBLISH body parser.
`timescale 1ns / 1ps

package mpp_pkg;

    // Field widths
    localparam int BODY_W  = 28;
    localparam int CAP_W   = 11;
    localparam int KEPT_W  = 10;
    localparam int TLEN_W  = 16;
    localparam int TEND_W  = TLEN_W + 1;
    localparam int IDEND_W = TLEN_W + 2;

    // Topic buffer limits
    localparam int              MAX_TOPIC_BUFFER = 1024;
    localparam logic [CAP_W-1:0] CAP_RESET       = CAP_W'(256);

    // Configuration port: one 32-bit register per word
    localparam int               APB_ADDR_W         = 3;
    localparam int               APB_DATA_W         = 32;
    localparam logic             REG_TOPIC_CAPACITY = 1'b0;

    // Packet type in the fixed header
    localparam logic [3:0] TYPE_PUBLISH = 4'd3;

    // Result kinds
    localparam logic [1:0] KIND_TOPIC   = 2'd0;
    localparam logic [1:0] KIND_PAYLOAD = 2'd1;
    localparam logic [1:0] KIND_HDR_OK  = 2'd2;
    localparam logic [1:0] KIND_ERROR   = 2'd3;

    // Error codes
    localparam logic [1:0] ERR_NOT_PUBLISH = 2'd0;
    localparam logic [1:0] ERR_SHORT_BODY  = 2'd1;
    localparam logic [1:0] ERR_TOPIC_OVR   = 2'd2;
    localparam logic [1:0] ERR_PKTID_OVR   = 2'd3;

    // Parser phase, one-hot
    typedef enum logic [5:0] {
        PH_IDLE    = 6'b000001,
        PH_LEN_HI  = 6'b000010,
        PH_LEN_LO  = 6'b000100,
        PH_TOPIC   = 6'b001000,
        PH_PKTID   = 6'b010000,
        PH_PAYLOAD = 6'b100000
    } phase_t;

    // One result beat
    typedef struct packed {
        logic [1:0]        kind;
        logic [7:0]        out_byte;
        logic [KEPT_W-1:0] topic_kept;
        logic [BODY_W-1:0] payload_length;
        logic [1:0]        error_code;
    } result_t;

endpackage

>>> design/mqtt_publish_body_parser.sv
// Top level of the MQTT 3.1.1 PUBLISH body parser.
`timescale 1ns / 1ps

// Takes one beat per clock: a start beat (s_action = 0) latching the fixed header and
// body length, or one body byte (s_action = 1). Each beat gives at most one result in the
// next cycle from a single output register; s_ready stays high while that register
// is empty or being drained, so a stream runs at one beat per cycle and the rate is set
// only by m_ready. Results are topic bytes (kind 0, up to topic_capacity-1 kept), payload
// bytes (kind 1), header-parsed status with kept topic length and payload length (kind 2)
// on the second topic-length byte, or an error (kind 3). After an error or the body end,
// bytes are ignored until the next start. topic_capacity is at byte address 0 of the
// APB port and resets to 256; write it only while the parser is idle.
module mqtt_publish_body_parser
    import mpp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,

    input  logic                  s_valid,
    output logic                  s_ready,
    input  logic                  s_action,
    input  logic [7:0]            s_header,
    input  logic [BODY_W-1:0]     s_body_size,
    input  logic [7:0]            s_data_byte,

    output logic                  m_valid,
    input  logic                  m_ready,
    output logic [1:0]            m_kind,
    output logic [7:0]            m_out_byte,
    output logic [KEPT_W-1:0]     m_topic_kept,
    output logic [BODY_W-1:0]     m_payload_length,
    output logic [1:0]            m_error_code,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic             acc;
    logic             res_valid;
    result_t          res;
    result_t          m_res;
    logic [CAP_W-1:0] topic_capacity;

    assign acc = s_valid && s_ready;

    // Configuration registers
    mpp_cfg u_cfg (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .topic_capacity (topic_capacity)
    );

    // Parser
    mpp_core u_core (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .acc            (acc),
        .s_action       (s_action),
        .s_header       (s_header),
        .s_body_size    (s_body_size),
        .s_data_byte    (s_data_byte),
        .topic_capacity (topic_capacity),
        .res_valid      (res_valid),
        .res            (res)
    );

    // Result register
    mpp_out u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (acc),
        .res_valid (res_valid),
        .res       (res),
        .m_ready   (m_ready),
        .m_valid   (m_valid),
        .m_res     (m_res),
        .free      (s_ready)
    );

    assign m_kind           = m_res.kind;
    assign m_out_byte       = m_res.out_byte;
    assign m_topic_kept     = m_res.topic_kept;
    assign m_payload_length = m_res.payload_length;
    assign m_error_code     = m_res.error_code;

endmodule

>>> design/mpp_cfg.sv
// Configuration register block: topic capacity behind an APB-style port.
`timescale 1ns / 1ps

module mpp_cfg
    import mpp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [CAP_W-1:0]      topic_capacity
);

    logic [CAP_W-1:0] cap_reg;
    logic             sel_cap;

    // Decode the word index
    assign sel_cap = (paddr[APB_ADDR_W-1] == REG_TOPIC_CAPACITY);

    // Write on the access phase
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cap_reg <= CAP_RESET;
        end else if (psel && penable && pwrite && pready && sel_cap) begin
            cap_reg <= pwdata[CAP_W-1:0];
        end
    end

    // Read back
    always_comb begin
        prdata = '0;
        if (sel_cap) begin
            prdata = {{(APB_DATA_W-CAP_W){1'b0}}, cap_reg};
        end
    end

    assign pready         = 1'b1;
    assign topic_capacity = cap_reg;

endmodule

>>> design/mpp_core.sv
// Parser state machine: body position tracking and per-beat result.
`timescale 1ns / 1ps

module mpp_core
    import mpp_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              acc,
    input  logic              s_action,
    input  logic [7:0]        s_header,
    input  logic [BODY_W-1:0] s_body_size,
    input  logic [7:0]        s_data_byte,
    input  logic [CAP_W-1:0]  topic_capacity,
    output logic              res_valid,
    output result_t           res
);

    phase_t              phase_reg, phase_next;
    logic [BODY_W-1:0]   pos_reg, pos_next;
    logic [BODY_W-1:0]   body_size_reg, body_size_next;
    logic [7:0]          len_hi_reg, len_hi_next;
    logic [TEND_W-1:0]   topic_end_reg, topic_end_next;
    logic [IDEND_W-1:0]  id_end_reg, id_end_next;
    logic [TLEN_W-1:0]   seen_reg, seen_next;
    logic                qos_nz_reg, qos_nz_next;

    logic [BODY_W-1:0]   pos_inc;
    logic [TLEN_W-1:0]   tlen_new;
    logic [TEND_W-1:0]   tend_new;
    logic [IDEND_W-1:0]  idend_new;
    logic [KEPT_W-1:0]   limit;
    logic [KEPT_W-1:0]   kept;

    // Phase that handles the byte at a given body position
    function automatic phase_t phase_at(input logic [BODY_W-1:0]  pos,
                                        input logic [TEND_W-1:0]  tend,
                                        input logic [IDEND_W-1:0] idend,
                                        input logic [BODY_W-1:0]  blen);
        phase_t ph;
        if (pos < BODY_W'(tend)) begin
            ph = PH_TOPIC;
        end else if (pos < BODY_W'(idend)) begin
            ph = PH_PKTID;
        end else if (pos < blen) begin
            ph = PH_PAYLOAD;
        end else begin
            ph = PH_IDLE;
        end
        return ph;
    endfunction

    // Kept-byte limit: capacity minus one, capacity clamped to 1..max
    always_comb begin
        if (topic_capacity == '0) begin
            limit = '0;
        end else if (topic_capacity > CAP_W'(MAX_TOPIC_BUFFER)) begin
            limit = KEPT_W'(MAX_TOPIC_BUFFER - 1);
        end else begin
            limit = KEPT_W'(topic_capacity - CAP_W'(1));
        end
    end

    // Topic bounds once the second length byte arrives
    assign pos_inc   = pos_reg + BODY_W'(1);
    assign tlen_new  = {len_hi_reg, s_data_byte};
    assign tend_new  = TEND_W'(tlen_new) + TEND_W'(2);
    assign idend_new = IDEND_W'(tend_new) + (qos_nz_reg ? IDEND_W'(2) : IDEND_W'(0));
    assign kept      = (tlen_new < TLEN_W'(limit)) ? tlen_new[KEPT_W-1:0] : limit;

    // Next state and result
    always_comb begin
        phase_next     = phase_reg;
        pos_next       = pos_reg;
        body_size_next = body_size_reg;
        len_hi_next    = len_hi_reg;
        topic_end_next = topic_end_reg;
        id_end_next    = id_end_reg;
        seen_next      = seen_reg;
        qos_nz_next    = qos_nz_reg;
        res_valid      = 1'b0;
        res            = '0;

        if (!s_action) begin
            // Start: latch header and length, check type and size
            pos_next       = '0;
            body_size_next = s_body_size;
            len_hi_next    = '0;
            seen_next      = '0;
            qos_nz_next    = (s_header[2:1] != 2'b00);
            phase_next     = PH_IDLE;
            if (s_header[7:4] != TYPE_PUBLISH) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_NOT_PUBLISH;
            end else if (s_body_size < BODY_W'(2)) begin
                res_valid      = 1'b1;
                res.kind       = KIND_ERROR;
                res.error_code = ERR_SHORT_BODY;
            end else begin
                phase_next = PH_LEN_HI;
            end
        end else begin
            unique case (phase_reg)
                PH_LEN_HI: begin
                    len_hi_next = s_data_byte;
                    pos_next    = BODY_W'(1);
                    phase_next  = PH_LEN_LO;
                end
                PH_LEN_LO: begin
                    pos_next       = BODY_W'(2);
                    topic_end_next = tend_new;
                    id_end_next    = idend_new;
                    res_valid      = 1'b1;
                    if (BODY_W'(tend_new) > body_size_reg) begin
                        phase_next     = PH_IDLE;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_TOPIC_OVR;
                    end else if (BODY_W'(idend_new) > body_size_reg) begin
                        phase_next     = PH_IDLE;
                        res.kind       = KIND_ERROR;
                        res.error_code = ERR_PKTID_OVR;
                    end else begin
                        phase_next         = phase_at(BODY_W'(2), tend_new, idend_new,
                                                      body_size_reg);
                        res.kind           = KIND_HDR_OK;
                        res.topic_kept     = kept;
                        res.payload_length = body_size_reg - BODY_W'(idend_new);
                    end
                end
                PH_TOPIC: begin
                    // Emit up to the limit, drop the rest
                    seen_next  = seen_reg + TLEN_W'(1);
                    pos_next   = pos_inc;
                    phase_next = phase_at(pos_inc, topic_end_reg, id_end_reg, body_size_reg);
                    if (seen_reg < TLEN_W'(limit)) begin
                        res_valid    = 1'b1;
                        res.kind     = KIND_TOPIC;
                        res.out_byte = s_data_byte;
                    end
                end
                PH_PKTID: begin
                    pos_next   = pos_inc;
                    phase_next = phase_at(pos_inc, topic_end_reg, id_end_reg, body_size_reg);
                end
                PH_PAYLOAD: begin
                    pos_next     = pos_inc;
                    phase_next   = phase_at(pos_inc, topic_end_reg, id_end_reg, body_size_reg);
                    res_valid    = 1'b1;
                    res.kind     = KIND_PAYLOAD;
                    res.out_byte = s_data_byte;
                end
                PH_IDLE: begin
                    // Ignore bytes until the next start
                end
                default: begin
                    phase_next = PH_IDLE;
                end
            endcase
        end
    end

    // Advance on each accepted beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= PH_IDLE;
            pos_reg       <= '0;
            body_size_reg <= '0;
            len_hi_reg    <= '0;
            topic_end_reg <= '0;
            id_end_reg    <= '0;
            seen_reg      <= '0;
            qos_nz_reg    <= 1'b0;
        end else if (acc) begin
            phase_reg     <= phase_next;
            pos_reg       <= pos_next;
            body_size_reg <= body_size_next;
            len_hi_reg    <= len_hi_next;
            topic_end_reg <= topic_end_next;
            id_end_reg    <= id_end_next;
            seen_reg      <= seen_next;
            qos_nz_reg    <= qos_nz_next;
        end
    end

    // Topic phase only while the position lies inside the topic
    a_topic_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_TOPIC |-> pos_reg < BODY_W'(topic_end_reg))
        else $error("topic phase beyond topic end");

    // Payload phase only while the position lies inside the body
    a_payload_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_PAYLOAD |-> pos_reg < body_size_reg)
        else $error("payload phase beyond body end");

    // Second length byte always reports header status or an error
    a_len_lo_reports: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && s_action && phase_reg == PH_LEN_LO |-> res_valid)
        else $error("second length byte gave no result");

    // A start with the wrong packet type leaves the parser idle
    a_bad_type_idles: assert property (@(posedge aclk) disable iff (!aresetn)
        acc && !s_action && s_header[7:4] != TYPE_PUBLISH |=> phase_reg == PH_IDLE)
        else $error("parser not idle after wrong packet type");

endmodule

>>> design/mpp_out.sv
// Result register: holds one result beat until the downstream side takes it.
`timescale 1ns / 1ps

module mpp_out
    import mpp_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    load,
    input  logic    res_valid,
    input  result_t res,
    input  logic    m_ready,
    output logic    m_valid,
    output result_t m_res,
    output logic    free
);

    logic    valid_reg;
    result_t res_reg;

    // Room for a new beat when empty or being drained this cycle
    assign free = !valid_reg || m_ready;

    // Valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= res_valid;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        if (load && res_valid) begin
            res_reg <= res;
        end
    end

    assign m_valid = valid_reg;
    assign m_res   = res_reg;

endmodule
